### hw/rtl/assert_macros.svh
// Assertion macros for the Modbus RTU response decoder checkers.
// Included by the checker file; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rmd_pkg.sv
// Shared types, constants and functions of the Modbus RTU response decoder.
// No dependencies; imported by the decoder modules and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rmd_pkg;

  localparam int MAX_FRAME_DEF = 256;
  localparam int SLOTS_DEF     = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_SIZE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_TYPE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_ORDER    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER    = 3'd4;

  // Value types
  localparam logic [2:0] TYPE_INT16   = 3'd0;
  localparam logic [2:0] TYPE_UINT16  = 3'd1;
  localparam logic [2:0] TYPE_INT32   = 3'd2;
  localparam logic [2:0] TYPE_FLOAT32 = 3'd4;

  // Function codes
  localparam logic [7:0] FC_READ_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    ST_VALUE_OK     = 3'd0,
    ST_COILS_OK     = 3'd1,
    ST_UNKNOWN_FUNC = 3'd2,
    ST_CRC_ERROR    = 3'd3,
    ST_EXCEPTION    = 3'd4,
    ST_BAD_TYPE     = 3'd5,
    ST_SHORT_FRAME  = 3'd6,
    ST_TOO_LONG     = 3'd7
  } status_t;

  typedef struct packed {
    logic [6:0] value_count;
    logic       register_size;
    logic [2:0] value_type;
    logic       word_order;
    logic       byte_order;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic [4:0] slot;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value_bits;
    logic [2:0]  value_kind;
    logic [7:0]  exception_code;
    logic [7:0]  function_code;
    logic [4:0]  slot_out;
  } result_t;

  // One byte through the reflected CRC-16, a bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Bytes per value: 0 for a type that is invalid with this register size
  function automatic logic [2:0] value_width(input cfg_t cfg);
    logic [2:0] w;
    if (cfg.register_size) begin
      w = (cfg.value_type >= TYPE_INT32 && cfg.value_type <= TYPE_FLOAT32) ? 3'd4 : 3'd0;
    end else if (cfg.value_type <= TYPE_UINT16) begin
      w = 3'd2;
    end else begin
      w = (cfg.value_type <= TYPE_FLOAT32) ? 3'd4 : 3'd0;
    end
    return w;
  endfunction

  // Number of values to decode from the frame
  function automatic logic [6:0] value_total(input cfg_t cfg);
    logic [2:0] w;
    logic [6:0] n;
    w = value_width(cfg);
    if (w == 3'd0) begin
      n = 7'd0;
    end else if (!cfg.register_size && w == 3'd4) begin
      n = cfg.value_count >> 1;
    end else begin
      n = cfg.value_count;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rmd_ifs.sv
// Valid/ready channel interfaces for the Modbus RTU response decoder.
// Standalone; used by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;
  logic [4:0] slot;

  modport source (output valid, rx_byte, last_byte, slot, input ready);
  modport sink (input valid, rx_byte, last_byte, slot, output ready);
endinterface

interface rmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_bits;
  logic [2:0]  value_kind;
  logic [7:0]  exception_code;
  logic [7:0]  function_code;
  logic [4:0]  slot_out;

  modport source (output valid, status, value_bits, value_kind, exception_code,
                  function_code, slot_out, input ready);
  modport sink (input valid, status, value_bits, value_kind, exception_code,
                function_code, slot_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/rmd_in_stage.sv
// Input register of the decoder: holds one received byte item until the
// frame logic takes it. Depends on rmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmd_pkg::item_t in_item,
  input  logic           advance,
  output logic           s_valid,
  output rmd_pkg::item_t s_item
);
  import rmd_pkg::*;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item <= in_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rmd_frame.sv
// Frame state of the decoder: delay of the two newest bytes, CRC, function
// code capture, value assembly and the end-of-frame status. Depends on rmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmd_frame #(
  parameter int MAX_FRAME = rmd_pkg::MAX_FRAME_DEF,
  parameter int SLOTS     = rmd_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  rmd_pkg::item_t   item,
  input  rmd_pkg::cfg_t    cfg,
  output rmd_pkg::result_t result
);
  import rmd_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME + 2);
  localparam int LEN_W = (POS_W > 10) ? POS_W : 10;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);

  logic [15:0]      crc_accum, crc_accum_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      held_bytes, held_bytes_next;
  logic [7:0]       func_byte, func_byte_next;
  logic [7:0]       exc_byte, exc_byte_next;
  logic [31:0]      assembly_word, assembly_word_next;
  logic [1:0]       bytes_in_word, bytes_in_word_next;
  logic [6:0]       values_done, values_done_next;
  logic [31:0]      last_value, last_value_next;

  logic [7:0]       take_b;
  logic             take;
  logic [POS_W-1:0] take_pos;
  logic [2:0]       width;
  logic [6:0]       total;
  logic             decode_en;
  logic [1:0]       lane;
  logic [31:0]      asm_base;
  logic [31:0]      asm_new;
  logic             word_done;
  logic [31:0]      word_value;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] need;
  logic             crc_bad;
  logic [4:0]       slot_tbl [32];

  // Slot reduction table, worked out at elaboration
  for (genvar g = 0; g < 32; g++) begin : g_slot
    assign slot_tbl[g] = 5'(g % SLOTS);
  end

  assign take_b    = held_bytes[15:8];
  assign take      = byte_position >= POS_W'(2);
  assign take_pos  = byte_position - POS_W'(2);
  assign width     = value_width(cfg);
  assign total     = value_total(cfg);
  assign decode_en = take && (take_pos >= POS_W'(3)) &&
                     (func_byte == FC_READ_HOLDING || func_byte == FC_READ_INPUT_REGS) &&
                     (width != 3'd0) && (values_done < total);

  // Byte lane of the arriving data byte
  assign lane = (width == 3'd4) ? (bytes_in_word ^ {cfg.word_order, cfg.byte_order})
                                : {1'b0, bytes_in_word[0] ^ cfg.byte_order};
  assign asm_base  = (bytes_in_word == 2'd0) ? 32'h0 : assembly_word;
  assign asm_new   = asm_base | ({24'h0, take_b} << {lane, 3'b000});
  assign word_done = (width == 3'd4) ? (bytes_in_word == 2'd3) : (bytes_in_word != 2'd0);

  always_comb begin
    if (width == 3'd4) begin
      word_value = asm_new;
    end else if (cfg.value_type == TYPE_INT16) begin
      word_value = {{16{asm_new[15]}}, asm_new[15:0]};
    end else begin
      word_value = {16'h0, asm_new[15:0]};
    end
  end

  // Advance the frame state by one byte
  always_comb begin
    crc_accum_next     = crc_accum;
    func_byte_next     = func_byte;
    exc_byte_next      = exc_byte;
    assembly_word_next = assembly_word;
    bytes_in_word_next = bytes_in_word;
    values_done_next   = values_done;
    last_value_next    = last_value;
    if (take) begin
      crc_accum_next = crc16_byte(crc_accum, take_b);
      if (take_pos == POS_W'(1)) begin
        func_byte_next = take_b;
      end
      if (take_pos == POS_W'(2)) begin
        exc_byte_next = take_b;
      end
    end
    if (decode_en) begin
      assembly_word_next = asm_new;
      if (word_done) begin
        last_value_next    = word_value;
        values_done_next   = values_done + 7'd1;
        bytes_in_word_next = 2'd0;
      end else begin
        bytes_in_word_next = bytes_in_word + 2'd1;
      end
    end
    held_bytes_next    = {held_bytes[7:0], item.rx_byte};
    byte_position_next = (byte_position <= POS_MAX) ? byte_position + POS_W'(1)
                                                    : byte_position;
  end

  // End-of-frame status
  assign len     = LEN_W'(byte_position_next);
  assign need    = LEN_W'(5) + ((width == 3'd4) ? LEN_W'({total, 2'b00})
                                                : LEN_W'({total, 1'b0}));
  assign crc_bad = (crc_accum_next[7:0] != held_bytes_next[15:8]) ||
                   (crc_accum_next[15:8] != held_bytes_next[7:0]);

  always_comb begin
    result.status         = ST_UNKNOWN_FUNC;
    result.value_bits     = 32'h0;
    result.value_kind     = 3'd0;
    result.exception_code = 8'h0;
    result.function_code  = func_byte_next;
    result.slot_out       = slot_tbl[item.slot];
    priority if (len > LEN_W'(MAX_FRAME)) begin
      result.status = ST_TOO_LONG;
    end else if (len < LEN_W'(4)) begin
      result.status = ST_SHORT_FRAME;
    end else if (crc_bad) begin
      result.status = ST_CRC_ERROR;
    end else if (func_byte_next[7]) begin
      if (len < LEN_W'(5)) begin
        result.status = ST_SHORT_FRAME;
      end else begin
        result.status         = ST_EXCEPTION;
        result.exception_code = exc_byte_next;
      end
    end else if (func_byte_next == FC_READ_COILS || func_byte_next == FC_READ_DISCRETE) begin
      result.status = ST_COILS_OK;
    end else if (func_byte_next == FC_READ_HOLDING ||
                 func_byte_next == FC_READ_INPUT_REGS) begin
      if (width == 3'd0) begin
        result.status = ST_BAD_TYPE;
      end else if (len < need) begin
        result.status = ST_SHORT_FRAME;
      end else begin
        result.status     = ST_VALUE_OK;
        result.value_bits = last_value_next;
        result.value_kind = cfg.value_type;
      end
    end else begin
      result.status = ST_UNKNOWN_FUNC;
    end
  end

  // Hold state between bytes; clear it after the last byte of a frame
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      crc_accum     <= CRC_INIT;
      byte_position <= '0;
      held_bytes    <= 16'h0;
      func_byte     <= 8'h0;
      exc_byte      <= 8'h0;
      assembly_word <= 32'h0;
      bytes_in_word <= 2'd0;
      values_done   <= 7'd0;
      last_value    <= 32'h0;
    end else if (step) begin
      crc_accum     <= crc_accum_next;
      byte_position <= byte_position_next;
      held_bytes    <= held_bytes_next;
      func_byte     <= func_byte_next;
      exc_byte      <= exc_byte_next;
      assembly_word <= assembly_word_next;
      bytes_in_word <= bytes_in_word_next;
      values_done   <= values_done_next;
      last_value    <= last_value_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rmd_out_reg.sv
// Result register of the decoder: holds one status item until the receiver
// takes it. Depends on rmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rmd_pkg::result_t load_data,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output rmd_pkg::result_t out_data
);
  import rmd_pkg::*;

  // Free when empty or when the held item leaves this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/modbus_rtu_response_decoder.sv
// Modbus RTU response decoder, top level.
// Takes response bytes on req (rx_byte, last_byte, slot) and gives one status
// item on rsp for each frame, on its last byte. Configuration is a plain write
// port: cfg_we, cfg_index and cfg_data, written at any edge with cfg_we high.
// An accepted byte is held in the input register; its result, if any, is
// loaded into the result register as the byte moves on, which raises rsp.valid.
// Throughput: one byte per cycle, but for a waiting last byte. The byte CRC,
// the value assembly and the status decision sit between the input register
// and the result register. A byte that does not end a frame moves on whether
// rsp is stalled or not; a last byte waits in the input register while the
// result register is full, and req.ready drops only then.
// Reset clears both registers, the frame state (CRC to all ones) and the
// configuration to: one value, 16-bit registers, uint16, low word and low
// byte first.
// Depends on rmd_pkg, rmd_ifs, rmd_in_stage, rmd_frame and rmd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_decoder #(
  parameter int MAX_FRAME = rmd_pkg::MAX_FRAME_DEF,
  parameter int SLOTS     = rmd_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  rmd_in_if.sink                           req,
  rmd_out_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [rmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rmd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    advance;
  logic    free;
  result_t frame_result;
  result_t out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_count   <= 7'd1;
      cfg.register_size <= 1'b0;
      cfg.value_type    <= TYPE_UINT16;
      cfg.word_order    <= 1'b0;
      cfg.byte_order    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALUE_COUNT:   cfg.value_count   <= cfg_data[6:0];
        REG_REGISTER_SIZE: cfg.register_size <= cfg_data[0];
        REG_VALUE_TYPE:    cfg.value_type    <= cfg_data[2:0];
        REG_WORD_ORDER:    cfg.word_order    <= cfg_data[0];
        REG_BYTE_ORDER:    cfg.byte_order    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.rx_byte   = req.rx_byte;
  assign in_item.last_byte = req.last_byte;
  assign in_item.slot      = req.slot;

  // A held byte moves on unless it ends a frame and the result register is full
  assign advance = s_valid && (!s_item.last_byte || free);

  rmd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_item  (in_item),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  rmd_frame #(
    .MAX_FRAME (MAX_FRAME),
    .SLOTS     (SLOTS)
  ) u_frame (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s_item),
    .cfg    (cfg),
    .result (frame_result)
  );

  rmd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && s_item.last_byte),
    .load_data (frame_result),
    .free      (free),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (out_data)
  );

  assign rsp.status         = out_data.status;
  assign rsp.value_bits     = out_data.value_bits;
  assign rsp.value_kind     = out_data.value_kind;
  assign rsp.exception_code = out_data.exception_code;
  assign rsp.function_code  = out_data.function_code;
  assign rsp.slot_out       = out_data.slot_out;

endmodule

`default_nettype wire

### hw/rtl/rmd_checker.sv
// Port-level checker of the Modbus RTU response decoder, bound to the top.
// Depends on rmd_pkg, rmd_ifs and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rmd_checker (
  input logic       clk,
  input logic       rst,
  rmd_in_if.sink    req,
  rmd_out_if.source rsp
);
  import rmd_pkg::*;

  // No item leaves right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !rsp.valid, "rsp valid after reset")

  // A stalled item holds
  `ASSERT_NEXT(a_stall_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.status) && $stable(rsp.value_bits) && $stable(rsp.slot_out), "stalled rsp item changed")

  // With the result register empty, bytes are always taken
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !rsp.valid, req.ready, "req stalled with no rsp pending")

  // Value fields are zero unless a value was decoded
  `ASSERT_IMPLY(a_value_only_ok, clk, rst, rsp.valid && rsp.status != ST_VALUE_OK, rsp.value_bits == 32'h0 && rsp.value_kind == 3'd0, "value fields set without value ok")

  // Exception code only with an exception status
  `ASSERT_IMPLY(a_exc_only_exc, clk, rst, rsp.valid && rsp.status != ST_EXCEPTION, rsp.exception_code == 8'h0, "exception code without exception")

endmodule

bind modbus_rtu_response_decoder rmd_checker u_rmd_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the Modbus RTU response decoder: directed frames, then random config phases.
// Results are checked against a predictor kept here. Depends on rmd_pkg, rmd_ifs and the top.

module tb;
  import rmd_pkg::*;

  localparam logic [2:0] VT_UINT32 = 3'd3;
  localparam logic [1:0] CRC_NONE  = 2'd0;
  localparam logic [1:0] CRC_GOOD  = 2'd1;
  localparam logic [1:0] CRC_BAD   = 2'd2;

  typedef struct packed {
    logic [2:0]  body_len;
    logic [39:0] body;      // first byte in the top bits
    logic [1:0]  crc_mode;
    logic [4:0]  slot;
    logic        typed;     // use want instead of the predictor
    result_t     want;
  } frame_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rmd_in_if  req_if ();
  rmd_out_if rsp_if ();

  modbus_rtu_response_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Decoder prediction state
  cfg_t        cfg_shadow;
  logic [15:0] crc_run;
  logic [8:0]  frame_pos;
  logic [15:0] delay_pair;
  logic [7:0]  fc_seen;
  logic [7:0]  exc_seen;
  logic [31:0] word_acc;
  int          lane_fill;
  int          decoded;
  logic [31:0] latest;

  result_t     pending_reports [$];
  logic [7:0]  frame_bytes [$];
  frame_row_t  dir_rows [6];
  bit          typed_pending;
  result_t     typed_want;
  bit          steady;
  bit          hold_rsp;
  int          bytes_fed;
  int          mismatches;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // CRC-16, reflected, one data bit at a time
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic int value_bytes(input cfg_t c);
    case (c.value_type)
      TYPE_INT16, TYPE_UINT16:           return c.register_size ? 0 : 2;
      TYPE_INT32, VT_UINT32, TYPE_FLOAT32: return 4;
      default:                           return 0;
    endcase
  endfunction

  function automatic int values_wanted(input cfg_t c);
    int w;
    w = value_bytes(c);
    if (w == 0) return 0;
    if (!c.register_size && w == 4) return c.value_count / 2;
    return c.value_count;
  endfunction

  function automatic void clear_frame();
    crc_run    = CRC_INIT;
    frame_pos  = '0;
    delay_pair = '0;
    fc_seen    = '0;
    exc_seen   = '0;
    word_acc   = '0;
    lane_fill  = 0;
    decoded    = 0;
    latest     = '0;
  endfunction

  // Take a byte that has left the two-byte delay: CRC, header, value lanes
  function automatic void absorb(input logic [7:0] b, input int pos);
    int w;
    logic [1:0] lane;
    crc_run = crc_step(crc_run, b);
    if (pos == 1) fc_seen = b;
    else if (pos == 2) exc_seen = b;
    if (pos < 3 || (fc_seen != FC_READ_HOLDING && fc_seen != FC_READ_INPUT_REGS)) return;
    w = value_bytes(cfg_shadow);
    if (w == 0 || decoded >= values_wanted(cfg_shadow)) return;
    if (lane_fill == 0) word_acc = '0;
    if (w == 4) lane = 2'(lane_fill) ^ {cfg_shadow.word_order, cfg_shadow.byte_order};
    else lane = {1'b0, 1'(lane_fill) ^ cfg_shadow.byte_order};
    word_acc[8*lane +: 8] = b;
    lane_fill++;
    if (lane_fill >= w) begin
      if (w == 4) latest = word_acc;
      else if (cfg_shadow.value_type == TYPE_INT16) latest = {{16{word_acc[15]}}, word_acc[15:0]};
      else latest = {16'h0000, word_acc[15:0]};
      decoded++;
      lane_fill = 0;
    end
  endfunction

  // Advance the predicted decoder by one byte; give the status item on the last byte
  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      input logic [4:0] s, output bit produced,
                                      output result_t r);
    int len;
    int need;
    r = '0;
    produced = 1'b0;
    if (frame_pos >= 2) absorb(delay_pair[15:8], int'(frame_pos) - 2);
    delay_pair = {delay_pair[7:0], b};
    if (frame_pos <= MAX_FRAME_DEF) frame_pos++;
    if (!last) return;
    produced = 1'b1;
    len = frame_pos;
    r.function_code = fc_seen;
    r.slot_out = s;
    if (len > MAX_FRAME_DEF) begin
      r.status = ST_TOO_LONG;
    end else if (len < 4) begin
      r.status = ST_SHORT_FRAME;
    end else if (crc_run != {delay_pair[7:0], delay_pair[15:8]}) begin
      r.status = ST_CRC_ERROR;
    end else if (fc_seen[7]) begin
      if (len < 5) begin
        r.status = ST_SHORT_FRAME;
      end else begin
        r.status = ST_EXCEPTION;
        r.exception_code = exc_seen;
      end
    end else if (fc_seen == FC_READ_COILS || fc_seen == FC_READ_DISCRETE) begin
      r.status = ST_COILS_OK;
    end else if (fc_seen == FC_READ_HOLDING || fc_seen == FC_READ_INPUT_REGS) begin
      need = 5 + values_wanted(cfg_shadow) * value_bytes(cfg_shadow);
      if (value_bytes(cfg_shadow) == 0) begin
        r.status = ST_BAD_TYPE;
      end else if (len < need) begin
        r.status = ST_SHORT_FRAME;
      end else begin
        r.status = ST_VALUE_OK;
        r.value_bits = latest;
        r.value_kind = cfg_shadow.value_type;
      end
    end else begin
      r.status = ST_UNKNOWN_FUNC;
    end
    clear_frame();
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Check every accepted status item against the oldest one awaited
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: item expected none, got status %0d fc %0h", $time,
                 rsp_if.status, rsp_if.function_code);
        mismatches++;
      end else begin
        typed_check : begin
          result_t want;
          want = pending_reports.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp_if.status));
          compare_field("value_bits", want.value_bits, rsp_if.value_bits);
          compare_field("value_kind", 32'(want.value_kind), 32'(rsp_if.value_kind));
          compare_field("exception_code", 32'(want.exception_code), 32'(rsp_if.exception_code));
          compare_field("function_code", 32'(want.function_code), 32'(rsp_if.function_code));
          compare_field("slot_out", 32'(want.slot_out), 32'(rsp_if.slot_out));
        end
      end
    end
  end

  // Drive rsp.ready: random idling, a steady stretch and one long hold-off
  initial begin
    int hold_left;
    rsp_if.ready = 1'b0;
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        for (hold_left = 64; hold_left > 0; hold_left--) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 12);
        @(negedge clk);
      end
    end
  end

  // Offer one byte and predict on acceptance; returns at the following falling edge
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [4:0] s);
    bit produced;
    result_t r;
    if (!steady && $urandom_range(99) < 12) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.rx_byte   <= b;
    req_if.last_byte <= last;
    req_if.slot      <= s;
    do @(posedge clk); while (!req_if.ready);
    decode_byte(b, last, s, produced, r);
    if (produced) pending_reports.push_back(typed_pending ? typed_want : r);
    bytes_fed++;
    @(negedge clk);
  endtask

  task automatic send_frame(input bit vary_slot, input logic [4:0] s);
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1,
                vary_slot ? 5'($urandom_range(31)) : s);
    end
  endtask

  // Append the CRC low byte first; damage one of the two bytes on request
  task automatic append_crc(input bit corrupt);
    logic [15:0] c;
    logic [7:0] flip;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = crc_step(c, frame_bytes[i]);
    if (corrupt) begin
      flip = 8'($urandom_range(1, 255));
      if ($urandom_range(1)) c[7:0] = c[7:0] ^ flip;
      else c[15:8] = c[15:8] ^ flip;
    end
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic build_long_frame(input int total);
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    frame_bytes.push_back(FC_READ_HOLDING);
    frame_bytes.push_back(8'd250);
    while (frame_bytes.size() < total - 2) frame_bytes.push_back(8'($urandom_range(255)));
    append_crc(1'b0);
  endtask

  // Mostly well-formed responses with random content; some damaged, runts and noise
  task automatic build_random_frame();
    int pick;
    int k;
    int w;
    bit corrupt;
    pick = $urandom_range(99);
    corrupt = ($urandom_range(9) == 0);
    w = value_bytes(cfg_shadow);
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(255)));
    if (pick < 60) begin
      frame_bytes.push_back($urandom_range(1) ? FC_READ_HOLDING : FC_READ_INPUT_REGS);
      k = (w == 0) ? $urandom_range(1, 6) : w * values_wanted(cfg_shadow);
      if (k > 40) begin
        k = $urandom_range(0, 40);
      end else begin
        case ($urandom_range(9))
          0: if (k > 0) k = $urandom_range(0, k - 1);
          1: k += $urandom_range(1, 3);
          default: ;
        endcase
      end
      frame_bytes.push_back(8'(k));
      repeat (k) frame_bytes.push_back(8'($urandom_range(255)));
      append_crc(corrupt);
    end else if (pick < 72) begin
      frame_bytes.push_back($urandom_range(1) ? FC_READ_COILS : FC_READ_DISCRETE);
      repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(255)));
      append_crc(corrupt);
    end else if (pick < 84) begin
      frame_bytes.push_back(8'h80 | 8'($urandom_range(127)));
      if ($urandom_range(3) != 0) frame_bytes.push_back(8'($urandom_range(255)));
      append_crc(corrupt);
    end else if (pick < 91) begin
      frame_bytes.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(5, 127)));
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(255)));
      append_crc(corrupt);
    end else if (pick < 96) begin
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 9)) frame_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  function automatic cfg_t phase_cfg(input int phase);
    cfg_t c;
    case (phase)
      0: c = '{7'd125, 1'b0, TYPE_INT16, 1'b1, 1'b1};
      1: c = '{7'd125, 1'b1, VT_UINT32, 1'b1, 1'b0};
      4: c = '{7'd1, 1'b0, TYPE_FLOAT32, 1'b0, 1'b1};
      5: c = '{7'd0, 1'b1, TYPE_INT32, 1'b0, 1'b0};
      default: begin
        case ($urandom_range(9))
          0:       c.value_count = 7'd0;
          1:       c.value_count = 7'($urandom_range(5, 12));
          2:       c.value_count = 7'($urandom_range(64, 127));
          default: c.value_count = 7'($urandom_range(1, 4));
        endcase
        c.register_size = 1'($urandom_range(1));
        c.value_type = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        c.word_order = 1'($urandom_range(1));
        c.byte_order = 1'($urandom_range(1));
      end
    endcase
    return c;
  endfunction

  // Write all five registers, one per cycle
  task automatic program_config(input cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_VALUE_COUNT;   cfg_data <= c.value_count;       @(negedge clk);
    cfg_index <= REG_REGISTER_SIZE; cfg_data <= 7'(c.register_size); @(negedge clk);
    cfg_index <= REG_VALUE_TYPE;    cfg_data <= 7'(c.value_type);    @(negedge clk);
    cfg_index <= REG_WORD_ORDER;    cfg_data <= 7'(c.word_order);    @(negedge clk);
    cfg_index <= REG_BYTE_ORDER;    cfg_data <= 7'(c.byte_order);    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  // Hold until every awaited item is back, then let the pipeline settle
  task automatic drain();
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase;
    int frames;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.rx_byte = '0;
    req_if.last_byte = 1'b0;
    req_if.slot = '0;
    steady = 1'b0;
    hold_rsp = 1'b0;
    typed_pending = 1'b0;
    bytes_fed = 0;
    mismatches = 0;
    cfg_shadow = '{7'd1, 1'b0, TYPE_UINT16, 1'b0, 1'b0};
    clear_frame();

    // Directed frames under the reset configuration
    dir_rows[0] = '{3'd1, {8'hFF, 32'h0}, CRC_NONE, 5'd31, 1'b1,
                    '{ST_SHORT_FRAME, 32'h0, 3'd0, 8'h00, 8'h00, 5'd31}};
    dir_rows[1] = '{3'd2, {8'h01, 8'h83, 24'h0}, CRC_GOOD, 5'd0, 1'b1,
                    '{ST_SHORT_FRAME, 32'h0, 3'd0, 8'h00, 8'h83, 5'd0}};
    dir_rows[2] = '{3'd3, {8'h11, 8'h84, 8'h02, 16'h0}, CRC_GOOD, 5'd5, 1'b1,
                    '{ST_EXCEPTION, 32'h0, 3'd0, 8'h02, 8'h84, 5'd5}};
    dir_rows[3] = '{3'd2, {8'h00, 8'h02, 24'h0}, CRC_BAD, 5'd17, 1'b1,
                    '{ST_CRC_ERROR, 32'h0, 3'd0, 8'h00, 8'h02, 5'd17}};
    dir_rows[4] = '{3'd2, {8'hFF, 8'h00, 24'h0}, CRC_GOOD, 5'd10, 1'b1,
                    '{ST_UNKNOWN_FUNC, 32'h0, 3'd0, 8'h00, 8'h00, 5'd10}};
    dir_rows[5] = '{3'd5, {8'h01, 8'h03, 8'h02, 8'hAB, 8'hCD}, CRC_GOOD, 5'd9, 1'b0,
                    '0};

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      frame_bytes.delete();
      for (int k = 0; k < dir_rows[i].body_len; k++) begin
        frame_bytes.push_back(dir_rows[i].body[39-8*k -: 8]);
      end
      if (dir_rows[i].crc_mode != CRC_NONE) append_crc(dir_rows[i].crc_mode == CRC_BAD);
      typed_pending = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      send_frame(1'b0, dir_rows[i].slot);
      typed_pending = 1'b0;
    end
    req_if.valid <= 1'b0;
    drain();

    // Random phases: configure while idle, then a batch of frames
    phase = 0;
    while (bytes_fed < 975) begin
      program_config(phase_cfg(phase));
      case (phase)
        0: begin
          build_long_frame(MAX_FRAME_DEF);
          send_frame(1'b1, 5'd0);
        end
        1: begin
          build_long_frame(MAX_FRAME_DEF + 1);
          send_frame(1'b1, 5'd0);
        end
        2: hold_rsp = 1'b1;
        3: steady = 1'b1;
        default: ;
      endcase
      frames = (phase == 2) ? 12 : $urandom_range(3, 8);
      repeat (frames) begin
        build_random_frame();
        send_frame(1'b1, 5'd0);
      end
      req_if.valid <= 1'b0;
      steady = 1'b0;
      drain();
      phase++;
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
